// File: hdl/tpa_pkg.sv
// ---------------------------------------------------------------------------
// tpa_pkg
// Shared widths, codes and types for triangle primitive assembly.
// ---------------------------------------------------------------------------
package tpa_pkg;

    localparam int INDEX_W         = 32;
    localparam int ADDR_W          = 32;
    localparam int COUNT_W         = 24;
    localparam int STRIDE_W        = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int OP_W            = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PRIM_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEXED      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TYPE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTR_BASE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTR_STRIDE  = 3'd5;

    // primitive modes
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_FAN   = 2'd1;
    localparam logic [1:0] MODE_STRIP = 2'd2;
    localparam logic [1:0] MODE_LINES = 2'd3;

    // index element widths
    localparam logic [1:0] IDX_BYTE  = 2'd0;
    localparam logic [1:0] IDX_SHORT = 2'd1;

    // operations handed from front to back
    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_A     = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_B     = 3'd2;
    localparam logic [OP_W-1:0] OP_EMIT_LIST  = 3'd3;
    localparam logic [OP_W-1:0] OP_EMIT_FAN   = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT_STRIP = 3'd5;

    typedef struct packed {
        logic [1:0]          prim_mode;
        logic                indexed;
        logic [1:0]          index_type;
        logic [COUNT_W-1:0]  vertex_count;
        logic [ADDR_W-1:0]   attr_base;
        logic [STRIDE_W-1:0] attr_stride;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  addr;
        logic               last_tri;
    } entry_t;

endpackage

// File: hdl/tpa_front.sv
// ---------------------------------------------------------------------------
// tpa_front
// Accepts vertex slots, tracks the draw position and classifies each slot.
// ---------------------------------------------------------------------------
module tpa_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tpa_pkg::cfg_t                cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tpa_pkg::INDEX_W-1:0]  s_vertex_index,
    input  logic                         q_full,
    output logic                         q_push,
    output tpa_pkg::entry_t              q_push_entry
);
    import tpa_pkg::*;

    logic [COUNT_W-1:0]          pos_reg, pos_next;
    logic [1:0]                  phase_reg, phase_next;
    logic                        accept;
    logic                        active;
    logic                        rewind;
    logic [INDEX_W-1:0]          vtx;
    logic [OP_W-1:0]             op;
    logic                        last_tri;
    logic [INDEX_W+STRIDE_W-1:0] product;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (cfg.indexed) begin
            case (cfg.index_type)
                IDX_BYTE:  vtx = {24'd0, s_vertex_index[7:0]};
                IDX_SHORT: vtx = {16'd0, s_vertex_index[15:0]};
                default:   vtx = s_vertex_index;
            endcase
        end else begin
            vtx = INDEX_W'(pos_reg);
        end
    end

    assign product = vtx * cfg.attr_stride;

    assign active = (cfg.prim_mode != MODE_LINES) && (cfg.vertex_count >= COUNT_W'(3));
    assign rewind = ({1'b0, pos_reg} + (COUNT_W+1)'(1)) >= {1'b0, cfg.vertex_count};

    always_comb begin
        op       = OP_NONE;
        last_tri = 1'b0;
        if (active) begin
            if (cfg.prim_mode == MODE_LIST) begin
                last_tri = ({1'b0, pos_reg} + (COUNT_W+1)'(4)) > {1'b0, cfg.vertex_count};
                case (phase_reg)
                    2'd0:    op = OP_LOAD_A;
                    2'd1:    op = OP_LOAD_B;
                    default: op = OP_EMIT_LIST;
                endcase
            end else begin
                last_tri = rewind;
                if (pos_reg == '0) begin
                    op = OP_LOAD_A;
                end else if (pos_reg == COUNT_W'(1)) begin
                    op = OP_LOAD_B;
                end else if (cfg.prim_mode == MODE_STRIP) begin
                    op = OP_EMIT_STRIP;
                end else begin
                    op = OP_EMIT_FAN;
                end
            end
        end
    end

    // phase tracks position modulo three
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (accept) begin
            if (rewind) begin
                pos_next   = '0;
                phase_next = 2'd0;
            end else begin
                pos_next   = pos_reg + COUNT_W'(1);
                phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= 2'd0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    assign q_push       = accept && (op != OP_NONE);
    assign q_push_entry = '{op:       op,
                            index:    vtx,
                            addr:     cfg.attr_base + product[ADDR_W-1:0],
                            last_tri: last_tri};

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase out of range");
    a_phase_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == '0 |-> phase_reg == 2'd0)
        else $error("phase not zero at draw start");
`endif

endmodule

// File: hdl/tpa_queue.sv
// ---------------------------------------------------------------------------
// tpa_queue
// Short request queue between the front and back parts.
// ---------------------------------------------------------------------------
module tpa_queue #(
    parameter int DEPTH = tpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tpa_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output tpa_pkg::entry_t pop_entry
);
    import tpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: hdl/tpa_back.sv
// ---------------------------------------------------------------------------
// tpa_back
// Holds the two kept corners and forms triangles into the output register.
// ---------------------------------------------------------------------------
module tpa_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  tpa_pkg::entry_t              q_entry,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tpa_pkg::INDEX_W-1:0]  m_corner0_index,
    output logic [tpa_pkg::INDEX_W-1:0]  m_corner1_index,
    output logic [tpa_pkg::INDEX_W-1:0]  m_corner2_index,
    output logic [tpa_pkg::ADDR_W-1:0]   m_corner0_addr,
    output logic [tpa_pkg::ADDR_W-1:0]   m_corner1_addr,
    output logic [tpa_pkg::ADDR_W-1:0]   m_corner2_addr,
    output logic                         m_final_triangle
);
    import tpa_pkg::*;

    logic [INDEX_W-1:0] idx_a_reg, idx_b_reg;
    logic [ADDR_W-1:0]  addr_a_reg, addr_b_reg;
    logic               m_valid_reg;
    logic [INDEX_W-1:0] out_idx0_reg, out_idx1_reg, out_idx2_reg;
    logic [ADDR_W-1:0]  out_addr0_reg, out_addr1_reg, out_addr2_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               is_emit;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;
    assign is_emit  = (q_entry.op == OP_EMIT_LIST) || (q_entry.op == OP_EMIT_FAN) ||
                      (q_entry.op == OP_EMIT_STRIP);

    // held corners
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_a_reg  <= '0;
            idx_b_reg  <= '0;
            addr_a_reg <= '0;
            addr_b_reg <= '0;
        end else if (q_pop) begin
            case (q_entry.op)
                OP_LOAD_A: begin
                    idx_a_reg  <= q_entry.index;
                    addr_a_reg <= q_entry.addr;
                end
                OP_LOAD_B, OP_EMIT_FAN: begin
                    idx_b_reg  <= q_entry.index;
                    addr_b_reg <= q_entry.addr;
                end
                OP_EMIT_STRIP: begin
                    idx_a_reg  <= idx_b_reg;
                    addr_a_reg <= addr_b_reg;
                    idx_b_reg  <= q_entry.index;
                    addr_b_reg <= q_entry.addr;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_emit) begin
            out_idx0_reg  <= idx_a_reg;
            out_idx1_reg  <= idx_b_reg;
            out_idx2_reg  <= q_entry.index;
            out_addr0_reg <= addr_a_reg;
            out_addr1_reg <= addr_b_reg;
            out_addr2_reg <= q_entry.addr;
            out_last_reg  <= q_entry.last_tri;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && is_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_corner0_index  = out_idx0_reg;
    assign m_corner1_index  = out_idx1_reg;
    assign m_corner2_index  = out_idx2_reg;
    assign m_corner0_addr   = out_addr0_reg;
    assign m_corner1_addr   = out_addr1_reg;
    assign m_corner2_addr   = out_addr2_reg;
    assign m_final_triangle = out_last_reg;

`ifndef NO_ASSERTIONS
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && is_emit |=> m_valid_reg)
        else $error("triangle lost in output register");
    a_pop_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!m_valid_reg || m_ready))
        else $error("pop while output register blocked");
`endif

endmodule

// File: hdl/triangle_primitive_assembly_top.sv
// ---------------------------------------------------------------------------
// triangle_primitive_assembly_top
// Triangle assembly for list, fan and strip draws from a vertex slot stream.
// ---------------------------------------------------------------------------
// One vertex slot is taken per request, one per clock cycle while not stalled,
// on s_valid/s_ready; each slot yields zero or one triangle on m_valid/m_ready.
// The front part picks the vertex index (masked index element or the running
// position), computes its attribute address base + index * stride mod 2^32
// with one 32x16 multiply, decides whether the slot loads a kept corner or
// closes a triangle, and pushes that into a short queue. The back part keeps
// the two held corners and loads finished triangles into an output register.
// A closing slot is queued and, once popped, its triangle is registered in the
// output register that drives m_valid. The rate is one slot per cycle while
// the output keeps moving, set by the single output register, which takes a
// new request in the cycle the old one leaves, so the queue stays below full.
// Slots that only advance the position (line mode, draws under three vertices)
// are dropped in the front and never queue. The user writes configuration
// over cfg_wr_en/cfg_index/cfg_data only while idle (not enforced here); it
// takes effect at once and never clears the draw position or held corners.
// ---------------------------------------------------------------------------
module triangle_primitive_assembly_top #(
    parameter int QUEUE_DEPTH = tpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [tpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    // vertex slot requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tpa_pkg::INDEX_W-1:0]     s_vertex_index,
    // triangle requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tpa_pkg::INDEX_W-1:0]     m_corner0_index,
    output logic [tpa_pkg::INDEX_W-1:0]     m_corner1_index,
    output logic [tpa_pkg::INDEX_W-1:0]     m_corner2_index,
    output logic [tpa_pkg::ADDR_W-1:0]      m_corner0_addr,
    output logic [tpa_pkg::ADDR_W-1:0]      m_corner1_addr,
    output logic [tpa_pkg::ADDR_W-1:0]      m_corner2_addr,
    output logic                            m_final_triangle
);
    import tpa_pkg::*;

    cfg_t   cfg_reg;
    logic   q_full;
    logic   q_push;
    entry_t q_push_entry;
    logic   q_pop;
    logic   q_valid;
    entry_t q_entry;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PRIM_MODE:    cfg_reg.prim_mode    <= cfg_data[1:0];
                REG_INDEXED:      cfg_reg.indexed      <= cfg_data[0];
                REG_INDEX_TYPE:   cfg_reg.index_type   <= cfg_data[1:0];
                REG_VERTEX_COUNT: cfg_reg.vertex_count <= cfg_data[COUNT_W-1:0];
                REG_ATTR_BASE:    cfg_reg.attr_base    <= cfg_data[ADDR_W-1:0];
                REG_ATTR_STRIDE:  cfg_reg.attr_stride  <= cfg_data[STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // position tracking and classification
    tpa_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vertex_index (s_vertex_index),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_push_entry   (q_push_entry)
    );

    // decoupling queue
    tpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    // held corners and output register
    tpa_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_corner0_index  (m_corner0_index),
        .m_corner1_index  (m_corner1_index),
        .m_corner2_index  (m_corner2_index),
        .m_corner0_addr   (m_corner0_addr),
        .m_corner1_addr   (m_corner1_addr),
        .m_corner2_addr   (m_corner2_addr),
        .m_final_triangle (m_final_triangle)
    );

endmodule
